@@ src/pda_pkg.sv @@
// shared types and constants for the pid controller with deadband and anti-windup
// no dependencies; imported by every module of the block

package pda_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ERR_W       = SAMPLE_W + 1;
    localparam int DIFF_W      = ERR_W + 1;
    localparam int SUM_W       = 40;
    localparam int PROD_W      = SUM_W + SAMPLE_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_BITS   = 9;
    localparam int HALF_W      = SUM_W / 2;
    localparam int CFG_INDEX_W = 3;
    localparam int USER_W      = 3;

    localparam logic signed [SAMPLE_W-1:0] OUT_MIN_RESET = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX_RESET = 16'sh7fff;
    localparam logic signed [SUM_W-1:0]    SUM_MAX       = 40'sh7f_ffff_ffff;
    localparam logic signed [SUM_W-1:0]    SUM_MIN       = 40'sh80_0000_0000;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_P_GAIN   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_I_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_D_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX  = 3'd6;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_HIGH = 2'd1,
        CLAMP_LOW  = 2'd2
    } clamp_t;

    typedef enum logic [2:0] {
        SEQ_RUN = 3'b001,
        SEQ_LO  = 3'b010,
        SEQ_HI  = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] target;
        logic signed [SAMPLE_W-1:0] p_gain;
        logic signed [SAMPLE_W-1:0] i_gain;
        logic signed [SAMPLE_W-1:0] d_gain;
        logic        [SAMPLE_W-1:0] deadband;
        logic signed [SAMPLE_W-1:0] out_min;
        logic signed [SAMPLE_W-1:0] out_max;
    } cfg_t;

endpackage

@@ src/pda_cfg_regs.sv @@
// configuration register file for the pid controller
// depends on pda_pkg for register indexes, reset values and the cfg_t bundle

module pda_cfg_regs
    import pda_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]    cfg_data,
    output cfg_t                   cfg,
    output logic                   i_gain_wr
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    // integral gain change means the cached gain*integral product is stale
    assign i_gain_wr = cfg_valid && (cfg_index == REG_I_GAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target   <= '0;
            cfg_reg.p_gain   <= '0;
            cfg_reg.i_gain   <= '0;
            cfg_reg.d_gain   <= '0;
            cfg_reg.deadband <= '0;
            cfg_reg.out_min  <= OUT_MIN_RESET;
            cfg_reg.out_max  <= OUT_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET:   cfg_reg.target   <= cfg_data;
                REG_P_GAIN:   cfg_reg.p_gain   <= cfg_data;
                REG_I_GAIN:   cfg_reg.i_gain   <= cfg_data;
                REG_D_GAIN:   cfg_reg.d_gain   <= cfg_data;
                REG_DEADBAND: cfg_reg.deadband <= cfg_data;
                REG_OUT_MIN:  cfg_reg.out_min  <= cfg_data;
                REG_OUT_MAX:  cfg_reg.out_max  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ src/pid_deadband_antiwindup_core.sv @@
// top level of the pid controller with deadband and anti-windup
// depends on pda_pkg and pda_cfg_regs

// One measured sample in, one drive sample out, at up to one transfer per clock
// while m_axis accepts and no gain rebuild runs. A sample passes an input
// register (error and deadband test) and then one combinational pass (three
// multiplies of 16 by 17 or 18 bits, sum, clamp, integrator update) into the
// output register, from which the result is presented on m_axis. The
// product of integral gain and stored integral is kept as a running value and
// updated with a short multiply per sample; after every write of the integral
// gain it is rebuilt from two partial products, which holds s_axis_tready low
// through the SEQ_LO and SEQ_HI states. Configuration writes are taken in any
// cycle but are meant for idle periods only.

module pid_deadband_antiwindup_core
    import pda_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]    cfg_data,
    // measured samples
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] measured
    // drive samples
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [SAMPLE_W-1:0]    m_axis_tdata,   // [15:0] drive
    output logic [USER_W-1:0]      m_axis_tuser    // [1:0] clamp_state, [2] held
);

    cfg_t       cfg;
    logic       i_gain_wr;
    seq_state_t seq_reg;
    seq_state_t seq_next;

    logic                     in_vld_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic                     held_reg;

    logic                     out_vld_reg;
    logic [SAMPLE_W-1:0]      drive_out_reg;
    clamp_t                   clamp_out_reg;
    logic                     held_out_reg;

    logic signed [ERR_W-1:0]    prev_error_reg;
    logic signed [SAMPLE_W-1:0] prev_drive_reg;
    logic signed [SUM_W-1:0]    esd_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [HALF_W+SAMPLE_W:0] part_reg;

    logic run;
    logic advance;
    logic fire;

    logic signed [ERR_W-1:0]    err_in;
    logic        [ERR_W-1:0]    mag_in;
    logic                       held_in;

    logic signed [ERR_W+SAMPLE_W-1:0]  p_prod;
    logic signed [DIFF_W-1:0]          diff;
    logic signed [DIFF_W+SAMPLE_W-1:0] d_prod;
    logic signed [DIFF_W-1:0]          delta;
    logic signed [DIFF_W+SAMPLE_W-1:0] i_step;
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-FRAC_BITS-1:0] raw;
    logic signed [ACC_W-FRAC_BITS-1:0] max_ext;
    logic signed [ACC_W-FRAC_BITS-1:0] min_ext;
    logic signed [SAMPLE_W-1:0]        drive_calc;
    clamp_t                            clamp_calc;
    logic                              do_int;
    logic signed [SUM_W:0]             sum_wide;
    logic                              sat_hi;
    logic                              sat_lo;
    logic signed [SUM_W-1:0]           esd_new;
    logic signed [PROD_W-1:0]          prod_new;

    logic signed [HALF_W+SAMPLE_W:0]   lo_prod;
    logic signed [HALF_W+SAMPLE_W-1:0] hi_prod;
    logic signed [PROD_W-1:0]          prod_rebuilt;

    pda_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .i_gain_wr (i_gain_wr)
    );

    // handshake
    assign run           = (seq_reg == SEQ_RUN);
    assign advance       = !out_vld_reg || m_axis_tready;
    assign fire          = run && in_vld_reg && advance;
    assign s_axis_tready = run && (!in_vld_reg || fire);

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = drive_out_reg;
    assign m_axis_tuser  = {held_out_reg, clamp_out_reg};

    // input stage: error and deadband test
    assign err_in  = $signed({cfg.target[SAMPLE_W-1], cfg.target})
                   - $signed({s_axis_tdata[SAMPLE_W-1], s_axis_tdata});
    assign mag_in  = err_in[ERR_W-1] ? ERR_W'(-err_in) : ERR_W'(err_in);
    assign held_in = mag_in < {1'b0, cfg.deadband};

    // pid pass
    assign p_prod = cfg.p_gain * err_reg;
    assign diff   = $signed({err_reg[ERR_W-1], err_reg})
                  - $signed({prev_error_reg[ERR_W-1], prev_error_reg});
    assign d_prod = cfg.d_gain * diff;
    assign delta  = $signed({err_reg[ERR_W-1], err_reg})
                  + $signed({prev_error_reg[ERR_W-1], prev_error_reg});
    assign i_step = cfg.i_gain * delta;

    assign acc = $signed({{(ACC_W-ERR_W-SAMPLE_W-1){p_prod[ERR_W+SAMPLE_W-1]}}, p_prod, 1'b0})
               + $signed({{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg})
               + $signed({{(ACC_W-DIFF_W-SAMPLE_W-1){d_prod[DIFF_W+SAMPLE_W-1]}},
                          d_prod, 1'b0});
    // dropping the fraction bits of a two's complement value is a floor
    assign raw     = acc[ACC_W-1:FRAC_BITS];
    assign max_ext = $signed({{(ACC_W-FRAC_BITS-SAMPLE_W){cfg.out_max[SAMPLE_W-1]}},
                              cfg.out_max});
    assign min_ext = $signed({{(ACC_W-FRAC_BITS-SAMPLE_W){cfg.out_min[SAMPLE_W-1]}},
                              cfg.out_min});

    always_comb
    begin
        if (raw > max_ext)
        begin
            drive_calc = cfg.out_max;
            clamp_calc = CLAMP_HIGH;
        end
        else if (raw < min_ext)
        begin
            drive_calc = cfg.out_min;
            clamp_calc = CLAMP_LOW;
        end
        else
        begin
            drive_calc = raw[SAMPLE_W-1:0];
            clamp_calc = CLAMP_NONE;
        end
    end

    // anti-windup: when clamped, integrate only toward unwinding
    assign do_int = (clamp_calc == CLAMP_NONE)
                 || ((err_reg != '0) && (esd_reg != '0)
                     && (err_reg[ERR_W-1] != esd_reg[SUM_W-1]));

    assign sum_wide = $signed({esd_reg[SUM_W-1], esd_reg})
                    + $signed({{(SUM_W+1-DIFF_W){delta[DIFF_W-1]}}, delta});
    assign sat_hi   = !sum_wide[SUM_W] && sum_wide[SUM_W-1];
    assign sat_lo   = sum_wide[SUM_W] && !sum_wide[SUM_W-1];

    always_comb
    begin
        if (sat_hi)
        begin
            esd_new  = SUM_MAX;
            // gain * (2^39 - 1)
            prod_new = $signed({cfg.i_gain[SAMPLE_W-1], cfg.i_gain, {(SUM_W-1){1'b0}}})
                     - $signed({{(PROD_W-SAMPLE_W){cfg.i_gain[SAMPLE_W-1]}}, cfg.i_gain});
        end
        else if (sat_lo)
        begin
            esd_new  = SUM_MIN;
            prod_new = -$signed({cfg.i_gain[SAMPLE_W-1], cfg.i_gain, {(SUM_W-1){1'b0}}});
        end
        else
        begin
            esd_new  = sum_wide[SUM_W-1:0];
            prod_new = prod_reg
                     + $signed({{(PROD_W-DIFF_W-SAMPLE_W){i_step[DIFF_W+SAMPLE_W-1]}},
                                i_step});
        end
    end

    // rebuild of gain*integral from low and high halves
    assign lo_prod      = cfg.i_gain * $signed({1'b0, esd_reg[HALF_W-1:0]});
    assign hi_prod      = cfg.i_gain * $signed(esd_reg[SUM_W-1:HALF_W]);
    assign prod_rebuilt = $signed({hi_prod, {HALF_W{1'b0}}})
                        + $signed({{(PROD_W-HALF_W-SAMPLE_W-1){part_reg[HALF_W+SAMPLE_W]}},
                                   part_reg});

    always_comb
    begin
        if (i_gain_wr)
        begin
            seq_next = SEQ_LO;
        end
        else
        begin
            unique case (seq_reg)
                SEQ_RUN: seq_next = SEQ_RUN;
                SEQ_LO:  seq_next = SEQ_HI;
                SEQ_HI:  seq_next = SEQ_RUN;
                default: seq_next = SEQ_RUN;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= SEQ_RUN;
        end
        else
        begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_reg == SEQ_LO)
        begin
            part_reg <= lo_prod;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            err_reg  <= err_in;
            held_reg <= held_in;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            prev_drive_reg <= '0;
            esd_reg        <= '0;
            prod_reg       <= '0;
        end
        else if (seq_reg == SEQ_HI)
        begin
            prod_reg <= prod_rebuilt;
        end
        else if (fire && !held_reg)
        begin
            prev_drive_reg <= drive_calc;
            if (do_int)
            begin
                prev_error_reg <= err_reg;
                esd_reg        <= esd_new;
                prod_reg       <= prod_new;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (held_reg)
            begin
                drive_out_reg <= prev_drive_reg;
                clamp_out_reg <= CLAMP_NONE;
                held_out_reg  <= 1'b1;
            end
            else
            begin
                drive_out_reg <= drive_calc;
                clamp_out_reg <= clamp_calc;
                held_out_reg  <= 1'b0;
            end
        end
    end

endmodule
